// File: rtl/core/mcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcp_pkg: shared types and defaults for the collinear point counter
// Default sizes, controller states and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package mcp_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_I,
    ST_RD_J,
    ST_RD_K,
    ST_DRAIN,
    ST_FINISH
  } mcp_state_t;

  // what a store read is for: anchor point, direction point, or test point
  typedef enum logic [1:0] {
    KIND_I,
    KIND_J,
    KIND_K
  } rd_kind_t;

  typedef struct packed {
    logic     wr_en;
    logic     rd_en;
    rd_kind_t rd_kind;
    logic     first_k;
    logic     last_k;
    logic     clear_best;
    logic     load_out;
    logic     small_set;
    logic     dropped;
  } mcp_cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/mcp_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcp_dpath: point store and cross-product pipeline
// Holds the point store, runs read/subtract/multiply/compare stages, keeps
// the running count and best count, and the result data register.
// ----------------------------------------------------------------------------
module mcp_dpath import mcp_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int AW    = $clog2(MAX_POINTS),
  localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mcp_cmd_t              cmd,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire logic [AW-1:0]         rd_addr,
  input  wire logic [COORD_BITS-1:0] wr_x,
  input  wire logic [COORD_BITS-1:0] wr_y,
  input  wire logic [CNT_W-1:0]      point_cnt,
  output logic                       pipe_busy,
  output logic [CNT_W-1:0]           res_cnt,
  output logic                       res_drop
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic [COORD_BITS-1:0] mem_x [MAX_POINTS];
  logic [COORD_BITS-1:0] mem_y [MAX_POINTS];

  // stage 1: registered read data
  logic [COORD_BITS-1:0] rx_r, ry_r;
  logic                  v1_r, f1_r, l1_r;
  rd_kind_t              kind1_r;
  // stage 2: differences
  logic [COORD_BITS-1:0] xi_r, yi_r;
  logic signed [DW-1:0]  dx_r, dy_r, ex_r, ey_r;
  logic                  v2_r, f2_r, l2_r;
  // stage 3: products
  logic signed [PW-1:0]  p1_r, p2_r;
  logic                  v3_r, f3_r, l3_r;
  // count stage
  logic [CNT_W-1:0]      cnt_r, best_r, cnt_cur, cnt_new;
  logic [CNT_W-1:0]      res_cnt_r;
  logic                  res_drop_r;
  logic signed [DW-1:0]  sub_x, sub_y;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rx_r <= mem_x[rd_addr];
      ry_r <= mem_y[rd_addr];
    end
  end

  // read point minus anchor, one bit wider so it cannot wrap
  assign sub_x = $signed({rx_r[COORD_BITS-1], rx_r}) - $signed({xi_r[COORD_BITS-1], xi_r});
  assign sub_y = $signed({ry_r[COORD_BITS-1], ry_r}) - $signed({yi_r[COORD_BITS-1], yi_r});

  always_ff @(posedge clk) begin
    if (v1_r) begin
      unique case (kind1_r)
        KIND_I: begin
          xi_r <= rx_r;
          yi_r <= ry_r;
        end
        KIND_J: begin
          dx_r <= sub_x;
          dy_r <= sub_y;
        end
        KIND_K: begin
          ex_r <= sub_x;
          ey_r <= sub_y;
        end
        default: begin
        end
      endcase
    end
    f1_r <= cmd.first_k;
    l1_r <= cmd.last_k;
    kind1_r <= cmd.rd_kind;
    f2_r <= f1_r;
    l2_r <= l1_r;
    // cross product terms of (Pj-Pi)x(Pk-Pi)
    p1_r <= PW'(dx_r) * PW'(ey_r);
    p2_r <= PW'(dy_r) * PW'(ex_r);
    f3_r <= f2_r;
    l3_r <= l2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r && (kind1_r == KIND_K);
      v3_r <= v2_r;
    end
  end

  assign cnt_cur = f3_r ? '0 : cnt_r;
  assign cnt_new = cnt_cur + CNT_W'(p1_r == p2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      best_r <= '0;
    end else begin
      if (v3_r) begin
        cnt_r <= cnt_new;
      end
      if (cmd.clear_best) begin
        best_r <= '0;
      end else if (v3_r && l3_r && (cnt_new > best_r)) begin
        best_r <= cnt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_cnt_r  <= cmd.small_set ? point_cnt : best_r;
      res_drop_r <= cmd.dropped;
    end
  end

  assign pipe_busy = v1_r | v2_r | v3_r;
  assign res_cnt   = res_cnt_r;
  assign res_drop  = res_drop_r;

endmodule
`default_nettype wire

// File: rtl/core/mcp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcp_ctrl: sequencer for loading and the pair/point sweep
// Counts loaded points, walks i<j pairs and every k, and hands the result
// to the output register.
// ----------------------------------------------------------------------------
module mcp_ctrl import mcp_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  localparam int AW    = $clog2(MAX_POINTS),
  localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tlast,
  output logic              in_tready,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  input  wire logic         pipe_busy,
  output mcp_cmd_t          cmd,
  output logic [AW-1:0]     wr_addr,
  output logic [AW-1:0]     rd_addr,
  output logic [CNT_W-1:0]  point_cnt
);

  mcp_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] n_r, n_nxt, n_after;
  logic             dropped_r, dropped_nxt;
  logic [AW-1:0]    i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept, has_room, out_free;
  logic             k_last, j_last, i_last;

  assign in_tready = (state_r == ST_LOAD);
  assign accept    = in_tvalid && in_tready;
  assign has_room  = n_r < CNT_W'(MAX_POINTS);
  assign n_after   = has_room ? n_r + CNT_W'(1) : n_r;
  assign out_free  = !out_valid_r || out_tready;
  assign k_last    = CNT_W'(k_r) == n_r - CNT_W'(1);
  assign j_last    = CNT_W'(j_r) == n_r - CNT_W'(1);
  assign i_last    = CNT_W'(i_r) == n_r - CNT_W'(2);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (accept && in_tlast) begin
          state_nxt = (n_after > CNT_W'(2)) ? ST_RD_I : ST_FINISH;
        end
      end
      ST_RD_I: state_nxt = ST_RD_J;
      ST_RD_J: state_nxt = ST_RD_K;
      ST_RD_K: begin
        if (k_last) begin
          state_nxt = (j_last && i_last) ? ST_DRAIN : ST_RD_I;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    cmd     = '0;
    cmd.rd_kind = KIND_I;
    rd_addr = i_r;
    wr_addr = n_r[AW-1:0];
    unique case (state_r)
      ST_LOAD: begin
        cmd.wr_en      = accept && has_room;
        cmd.clear_best = 1'b1;
      end
      ST_RD_I: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_kind = KIND_I;
        rd_addr     = i_r;
      end
      ST_RD_J: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_kind = KIND_J;
        rd_addr     = j_r;
      end
      ST_RD_K: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_kind = KIND_K;
        cmd.first_k = (k_r == '0);
        cmd.last_k  = k_last;
        rd_addr     = k_r;
      end
      ST_DRAIN: begin
      end
      ST_FINISH: begin
        cmd.load_out  = out_free;
        cmd.small_set = n_r <= CNT_W'(2);
        cmd.dropped   = dropped_r;
      end
      default: begin
      end
    endcase
  end

  // counters and flags
  always_comb begin
    n_nxt         = n_r;
    dropped_nxt   = dropped_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          n_nxt = n_after;
          if (!has_room) begin
            dropped_nxt = 1'b1;
          end
        end
        i_nxt = '0;
        j_nxt = AW'(1);
      end
      ST_RD_J: k_nxt = '0;
      ST_RD_K: begin
        k_nxt = k_r + AW'(1);
        if (k_last) begin
          if (j_last) begin
            i_nxt = i_r + AW'(1);
            j_nxt = i_r + AW'(2);
          end else begin
            j_nxt = j_r + AW'(1);
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          n_nxt         = '0;
          dropped_nxt   = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      n_r         <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign point_cnt  = n_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(MAX_POINTS))
    else $error("point count above store size");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (CNT_W'(rd_addr) < n_r))
    else $error("store read beyond loaded points");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINISH |-> !pipe_busy)
    else $error("result taken while pipeline busy");

  a_set_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (state_r == ST_LOAD) && (n_r == '0) && !dropped_r && out_valid_r)
    else $error("set not restarted after result");
`endif

endmodule
`default_nettype wire

// File: rtl/core/max_collinear_points.sv
`default_nettype none
// ----------------------------------------------------------------------------
// max_collinear_points: largest number of points on one line
// Top level: stream ports, controller and datapath.
// ----------------------------------------------------------------------------
// Usage:
//  - in_* carries one point per request: x in tdata[COORD_BITS-1:0], y above
//    it; in_tlast marks the final point of a set. Points load one per cycle.
//  - Points past MAX_POINTS are dropped and reported as capacity_exceeded.
//  - After the last point, sets of n > 2 are swept over every pair i<j: each
//    pair reads its anchor, its direction point and then every point k
//    through the single store read port. Sets of two points or fewer report
//    their count without a sweep.
//  - in_tready is low during the sweep; it returns as soon as the result sits
//    in the output register, so the next set can load while out_* waits.
//  - out_* carries one result per set. A stalled receiver holds the result;
//    a finished sweep then waits in place until the register frees up.
//  - Reset clears the count, drop flag and handshakes; the store is not
//    cleared since only loaded entries are read.
// ----------------------------------------------------------------------------
module max_collinear_points import mcp_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int CNT_W = $clog2(MAX_POINTS + 1),
  localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((CNT_W + 1 + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // x_coord, y_coord
  input  wire logic             in_tlast,   // last_point
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata   // max_on_line, capacity_exceeded
);

  localparam int AW = $clog2(MAX_POINTS);

  mcp_cmd_t         cmd;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [CNT_W-1:0] point_cnt, res_cnt;
  logic             pipe_busy, res_drop;

  mcp_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .pipe_busy  (pipe_busy),
    .cmd        (cmd),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .point_cnt  (point_cnt)
  );

  mcp_dpath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .wr_x      (in_tdata[COORD_BITS-1:0]),
    .wr_y      (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .point_cnt (point_cnt),
    .pipe_busy (pipe_busy),
    .res_cnt   (res_cnt),
    .res_drop  (res_drop)
  );

  // result packed from bit 0 up, zero filled to whole bytes
  assign out_tdata = OUT_W'({res_drop, res_cnt});

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the collinear point counter
// Loads point sets over the input stream, predicts the largest collinear count
// and the drop flag per set with an exact integer model, and checks every
// result on the output stream. A directed table runs first, then random sets
// run under four idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;
  import mcp_pkg::*;

  localparam int MAX_PTS = MAX_POINTS_DEF;
  localparam int PHASE_POINTS = 290;
  localparam logic [15:0] C_MIN = 16'h8000;
  localparam logic [15:0] C_MAX = 16'h7FFF;
  localparam logic [15:0] CORNERS [5] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};

  // out_tdata layout: max_on_line in [6:0], capacity_exceeded in [7]
  typedef struct packed {
    logic       capacity_exceeded;
    logic [6:0] max_on_line;
  } line_result_t;

  // one row of the directed table; a row repeats its point reps times
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
    logic [6:0]  reps;
    logic        typed;
    logic [6:0]  want_max;
    logic        want_cap;
  } dir_row_t;

  localparam dir_row_t DIRECTED [28] = '{
    // single point at the negative corner
    '{C_MIN, C_MIN, 1'b1, 7'd1, 1'b1, 7'd1, 1'b0},
    // two points report their count
    '{C_MAX, C_MAX, 1'b0, 7'd1, 1'b0, 7'd0, 1'b0},
    '{C_MIN, C_MIN, 1'b1, 7'd1, 1'b1, 7'd2, 1'b0},
    // full-range diagonal, widest differences
    '{C_MIN, C_MIN, 1'b0, 7'd1, 1'b0, 7'd0, 1'b0},
    '{16'hFFFF, 16'hFFFF, 1'b0, 7'd1, 1'b0, 7'd0, 1'b0},
    '{C_MAX, C_MAX, 1'b1, 7'd1, 1'b1, 7'd3, 1'b0},
    // triangle on the extremes
    '{C_MIN, C_MAX, 1'b0, 7'd1, 1'b0, 7'd0, 1'b0},
    '{C_MAX, C_MAX, 1'b0, 7'd1, 1'b0, 7'd0, 1'b0},
    '{16'h0000, C_MIN, 1'b1, 7'd1, 1'b1, 7'd2, 1'b0},
    // coincident pair pulls in every point
    '{16'd7, 16'd7, 1'b0, 7'd1, 1'b0, 7'd0, 1'b0},
    '{16'd7, 16'd7, 1'b0, 7'd1, 1'b0, 7'd0, 1'b0},
    '{16'd100, 16'hFFFD, 1'b0, 7'd1, 1'b0, 7'd0, 1'b0},
    '{16'd7, 16'd7, 1'b1, 7'd1, 1'b1, 7'd4, 1'b0},
    // mixed slopes, predicted
    '{16'd0, 16'd0, 1'b0, 7'd1, 1'b0, 7'd0, 1'b0},
    '{16'd1, 16'd1, 1'b0, 7'd1, 1'b0, 7'd0, 1'b0},
    '{16'd3, 16'd5, 1'b0, 7'd1, 1'b0, 7'd0, 1'b0},
    '{16'd2, 16'd2, 1'b0, 7'd1, 1'b0, 7'd0, 1'b0},
    '{16'd4, 16'hFFFE, 1'b0, 7'd1, 1'b0, 7'd0, 1'b0},
    '{16'hFFFF, 16'hFFFF, 1'b0, 7'd1, 1'b0, 7'd0, 1'b0},
    '{16'd2, 16'hFFFF, 1'b1, 7'd1, 1'b0, 7'd0, 1'b0},
    // vertical and horizontal lines, predicted
    '{16'd5, C_MIN, 1'b0, 7'd1, 1'b0, 7'd0, 1'b0},
    '{16'd5, 16'd0, 1'b0, 7'd1, 1'b0, 7'd0, 1'b0},
    '{16'd5, C_MAX, 1'b0, 7'd1, 1'b0, 7'd0, 1'b0},
    '{C_MIN, 16'd0, 1'b0, 7'd1, 1'b0, 7'd0, 1'b0},
    '{C_MAX, 16'd0, 1'b1, 7'd1, 1'b0, 7'd0, 1'b0},
    // full store of one point, the closing point is dropped
    '{16'd5, 16'hFFF7, 1'b0, 7'd64, 1'b0, 7'd0, 1'b0},
    '{C_MIN, C_MAX, 1'b1, 7'd1, 1'b1, 7'd64, 1'b1},
    // drop flag cleared for the next set
    '{C_MAX, C_MIN, 1'b1, 7'd1, 1'b1, 7'd1, 1'b0}
  };

  localparam int IDLE_PCT  [4] = '{0, 82, 0, 25};
  localparam int STALL_PCT [4] = '{0, 0, 82, 25};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;     // x_coord, y_coord
  logic        in_tlast = 1'b0;   // last_point
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // max_on_line, capacity_exceeded

  // predictor state
  logic signed [15:0] px [MAX_PTS];
  logic signed [15:0] py [MAX_PTS];
  int unsigned        pt_count = 0;
  bit                 overflow = 1'b0;

  line_result_t pending_lines[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int points_sent = 0;
  int sets_sent = 0;
  int results_seen = 0;
  int drop_results = 0;
  int longest_seen = 0;

  max_collinear_points DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  initial begin
    #30_000_000;
    $display("timeout with %0d results outstanding", pending_lines.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // exact count: differences fit 17 bits, cross products 34 bits
  function automatic logic [6:0] longest_line();
    int unsigned n, best, hits;
    logic signed [16:0] dx, dy, ex, ey;
    logic signed [33:0] lhs, rhs;
    n = pt_count;
    if (n <= 2) return n[6:0];
    best = 0;
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        dx = px[j] - px[i];
        dy = py[j] - py[i];
        hits = 0;
        for (int k = 0; k < n; k++) begin
          ex = px[k] - px[i];
          ey = py[k] - py[i];
          lhs = dx * ey;
          rhs = dy * ex;
          if (lhs == rhs) hits++;
        end
        if (hits > best) best = hits;
      end
    end
    return best[6:0];
  endfunction

  function automatic void load_point(input logic [15:0] x, input logic [15:0] y,
                                     input logic last, output bit done,
                                     output line_result_t res);
    res = '0;
    if (pt_count < MAX_PTS) begin
      px[pt_count] = x;
      py[pt_count] = y;
      pt_count++;
    end else begin
      overflow = 1'b1;
    end
    done = last;
    if (last) begin
      res.max_on_line = longest_line();
      res.capacity_exceeded = overflow;
      pt_count = 0;
      overflow = 1'b0;
    end
  endfunction

  // one request on the input side, then a random idle gap
  task automatic send_point(input logic [15:0] x, input logic [15:0] y, input logic last,
                            input bit typed, input line_result_t typed_res);
    bit done;
    line_result_t res;
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {y, x};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    load_point(x, y, last, done, res);
    points_sent++;
    if (done) begin
      pending_lines.insert(pending_lines.size(), typed ? typed_res : res);
      sets_sent++;
    end
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // random set: full-range noise, a small grid, a line with strays, or corners
  task automatic send_random_set(input int n);
    int style, bx, by, sx, sy, t;
    logic [15:0] x, y;
    style = $urandom_range(3);
    bx = $urandom_range(40000) - 20000;
    by = $urandom_range(40000) - 20000;
    sx = $urandom_range(100) - 50;
    sy = $urandom_range(100) - 50;
    for (int p = 0; p < n; p++) begin
      unique case (style)
        0: begin
          x = 16'($urandom);
          y = 16'($urandom);
        end
        1: begin
          x = 16'($urandom_range(6) - 3);
          y = 16'($urandom_range(6) - 3);
        end
        2: begin
          t = $urandom_range(200) - 100;
          x = 16'(bx + t * sx);
          y = 16'(by + t * sy);
          if ($urandom_range(3) == 0) begin
            x = x + 16'($urandom_range(4) - 2);
            y = y + 16'($urandom_range(4) - 2);
          end
        end
        default: begin
          x = CORNERS[$urandom_range(4)];
          y = CORNERS[$urandom_range(4)];
        end
      endcase
      send_point(x, y, p == n - 1, 1'b0, '0);
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin : check_results
    line_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      results_seen++;
      if (got.capacity_exceeded) drop_results++;
      if (got.max_on_line > longest_seen) longest_seen = got.max_on_line;
      if (pending_lines.size() == 0) begin
        note_failure($sformatf("unexpected result max_on_line=%0d capacity_exceeded=%0d",
                               got.max_on_line, got.capacity_exceeded));
      end else begin
        want = pending_lines.pop_front();
        if (got.max_on_line != want.max_on_line)
          note_failure($sformatf("max_on_line expected %0d got %0d",
                                 want.max_on_line, got.max_on_line));
        if (got.capacity_exceeded != want.capacity_exceeded)
          note_failure($sformatf("capacity_exceeded expected %0d got %0d",
                                 want.capacity_exceeded, got.capacity_exceeded));
      end
    end
  end

  initial begin
    dir_row_t row;
    int start_pts, setno, n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, no idling
    for (int r = 0; r < 28; r++) begin
      row = DIRECTED[r];
      for (int k = 0; k < row.reps; k++)
        send_point(row.x, row.y, row.last && (k == row.reps - 1), row.typed,
                   line_result_t'{row.want_cap, row.want_max});
    end

    // random sets, one idle/stall mix per phase; drain between phases
    for (int ph = 0; ph < 4; ph++) begin
      if (in_tvalid) in_tvalid <= 1'b0;
      while (pending_lines.size() != 0) @(posedge clk);
      idle_pct = IDLE_PCT[ph];
      stall_pct = STALL_PCT[ph];
      start_pts = points_sent;
      setno = 0;
      while (points_sent - start_pts < PHASE_POINTS) begin
        n = $urandom_range(99);
        if (n < 10) n = $urandom_range(2, 1);
        else if (n < 80) n = $urandom_range(8, 3);
        else n = $urandom_range(16, 9);
        // one near-full or overflowing set in two of the phases
        if (setno == 5 && (ph == 1 || ph == 3)) n = $urandom_range(72, 60);
        send_random_set(n);
        setno++;
      end
    end

    if (in_tvalid) in_tvalid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (pending_lines.size() != 0) note_failure("results still outstanding at end");

    $display("Ran %0d point sets (%0d points): %0d results, %0d with dropped points,",
             sets_sent, points_sent, results_seen, drop_results);
    $display("longest line %0d, under free-flowing, idle, stalled and mixed traffic; %0d errors",
             longest_seen, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
